// ----- rtl/ofd_pkg.sv -----
// Package with payload types and fixed constants of the framed message decoder.
`timescale 1ns / 1ps

package ofd_pkg;

  // Input request: one frame byte and its final-byte flag.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_req_t;

  // One verdict per frame.
  typedef struct packed {
    logic        frame_ok;
    logic [2:0]  fail_reason;
    logic [2:0]  msg_kind;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [15:0] seq_num;
    logic [31:0] flow_tag;
    logic [31:0] op_id_word;
    logic [7:0]  op_type_code;
    logic [26:0] value_word;
    logic [15:0] nack_code;
    logic [15:0] nack_detail;
  } out_res_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_VERSION = 3'd0;
  localparam logic [2:0] CFG_BEACON  = 3'd1;
  localparam logic [2:0] CFG_REQUEST = 3'd2;
  localparam logic [2:0] CFG_DATA    = 3'd3;
  localparam logic [2:0] CFG_ACK     = 3'd4;
  localparam logic [2:0] CFG_NACK    = 3'd5;
  localparam logic [2:0] CFG_ADD_OP  = 3'd6;
  localparam logic [2:0] CFG_REM_OP  = 3'd7;

  // Failure reasons.
  localparam logic [2:0] RSN_OK       = 3'd0;
  localparam logic [2:0] RSN_TYPE     = 3'd1;
  localparam logic [2:0] RSN_LENGTH   = 3'd2;
  localparam logic [2:0] RSN_CRC      = 3'd3;
  localparam logic [2:0] RSN_HEADER   = 3'd4;
  localparam logic [2:0] RSN_PAYLOAD  = 3'd5;

  // Message kinds.
  localparam logic [2:0] KIND_BEACON  = 3'd0;
  localparam logic [2:0] KIND_REQUEST = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_ACK     = 3'd3;
  localparam logic [2:0] KIND_NACK    = 3'd4;

  // Total frame lengths: 8 header bytes, payload, 2 CRC bytes.
  localparam logic [5:0] LEN_SHORT = 6'd18;
  localparam logic [5:0] LEN_DATA  = 6'd26;
  localparam logic [5:0] LEN_NACK  = 6'd22;

  localparam int unsigned STORE_BYTES = 24;
  localparam logic [5:0]  COUNT_MAX   = 6'd63;
  localparam logic [31:0] MAX_VALUE   = 32'd99999999;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

endpackage

// ----- rtl/op_frame_decoder_crc16.sv -----
// Top level of the framed message decoder with CRC-16/CCITT-FALSE check.
`timescale 1ns / 1ps

// Port group   Direction  Handshake              Payload
// in_          input      in_valid / in_stall    ofd_pkg::in_req_t
// out_         output     out_valid / out_stall  ofd_pkg::out_res_t
// cfg_         input      cfg_we                 cfg_index (3), cfg_data (8)
//
// One byte request is taken per cycle; the verdict of a frame is registered
// in the output register in the cycle after its final byte is taken.
// The byte-wise CRC step and the field checks all fit between the state
// registers and the output register, so the rate is one byte per cycle.
// A final byte is held off only while an earlier verdict is still stalled.
// Reset is synchronous; it restores the config, frame state and out_valid.

module op_frame_decoder_crc16 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ofd_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output ofd_pkg::out_res_t out_res,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ ofd_pkg::CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Configuration registers.
  logic [7:0] version_r, beacon_r, request_r, data_r, ack_r, nack_r, add_op_r, rem_op_r;

  // Frame state.
  logic [5:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  dly0_r, dly0_nxt, dly1_r, dly1_nxt;
  logic [7:0]  store_r [ofd_pkg::STORE_BYTES];

  logic              out_valid_r, out_valid_nxt;
  ofd_pkg::out_res_t out_res_r, res_nxt;

  logic        in_acc;
  logic        is_eof;
  logic [15:0] crc_fed;
  logic [7:0]  type_byte;
  logic [5:0]  frame_len;
  logic [5:0]  exp_len;
  logic [2:0]  kind;
  logic [2:0]  reason;
  logic [15:0] rx_crc;
  logic [15:0] snd, rcv, seq;
  logic [31:0] stream, opid, val;
  logic [15:0] ncode, ndet;
  logic [7:0]  optype;

  // Only a final byte has to wait for the output register to drain.
  assign in_stall = out_valid_r && out_stall && in_req.end_of_frame;
  assign in_acc   = in_valid && !in_stall;
  assign is_eof   = in_req.end_of_frame;

  // The oldest held byte enters the CRC once two bytes are behind it.
  assign crc_fed = (count_r >= 6'd2) ? crc_feed(crc_r, dly1_r) : crc_r;

  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    dly0_nxt  = dly0_r;
    dly1_nxt  = dly1_r;
    if (in_acc) begin
      if (is_eof) begin
        count_nxt = '0;
        crc_nxt   = ofd_pkg::CRC_INIT;
        dly0_nxt  = '0;
        dly1_nxt  = '0;
      end else begin
        crc_nxt   = crc_fed;
        dly1_nxt  = dly0_r;
        dly0_nxt  = in_req.rx_byte;
        if (count_r != ofd_pkg::COUNT_MAX) begin
          count_nxt = count_r + 6'd1;
        end
      end
    end
  end

  // Verdict for a frame whose final byte is being taken.
  always_comb begin
    // In a two-byte frame the type byte is the final byte itself.
    type_byte = (count_r == 6'd1) ? in_req.rx_byte : store_r[1];
    frame_len = (count_r == ofd_pkg::COUNT_MAX) ? ofd_pkg::COUNT_MAX : count_r + 6'd1;
    rx_crc    = {in_req.rx_byte, dly0_r};
    reason    = ofd_pkg::RSN_OK;
    kind      = ofd_pkg::KIND_BEACON;

    if (frame_len < 6'd2) begin
      reason = ofd_pkg::RSN_TYPE;
    end else if (type_byte == beacon_r) begin
      kind = ofd_pkg::KIND_BEACON;
    end else if (type_byte == request_r) begin
      kind = ofd_pkg::KIND_REQUEST;
    end else if (type_byte == data_r) begin
      kind = ofd_pkg::KIND_DATA;
    end else if (type_byte == ack_r) begin
      kind = ofd_pkg::KIND_ACK;
    end else if (type_byte == nack_r) begin
      kind = ofd_pkg::KIND_NACK;
    end else begin
      reason = ofd_pkg::RSN_TYPE;
    end

    case (kind)
      ofd_pkg::KIND_DATA: exp_len = ofd_pkg::LEN_DATA;
      ofd_pkg::KIND_NACK: exp_len = ofd_pkg::LEN_NACK;
      default:            exp_len = ofd_pkg::LEN_SHORT;
    endcase

    snd    = {store_r[3], store_r[2]};
    rcv    = {store_r[5], store_r[4]};
    seq    = {store_r[7], store_r[6]};
    stream = {store_r[11], store_r[10], store_r[9], store_r[8]};
    if (kind == ofd_pkg::KIND_NACK) begin
      ncode = {store_r[13], store_r[12]};
      ndet  = {store_r[15], store_r[14]};
      opid  = {store_r[19], store_r[18], store_r[17], store_r[16]};
    end else begin
      ncode = '0;
      ndet  = '0;
      opid  = {store_r[15], store_r[14], store_r[13], store_r[12]};
    end
    if (kind == ofd_pkg::KIND_DATA) begin
      optype = store_r[16];
      val    = {store_r[23], store_r[22], store_r[21], store_r[20]};
    end else begin
      optype = '0;
      val    = '0;
    end

    if (reason == ofd_pkg::RSN_OK && frame_len != exp_len) begin
      reason = ofd_pkg::RSN_LENGTH;
    end
    if (reason == ofd_pkg::RSN_OK && rx_crc != crc_fed) begin
      reason = ofd_pkg::RSN_CRC;
    end
    if (reason == ofd_pkg::RSN_OK) begin
      if (store_r[0] != version_r || snd == 16'd0) begin
        reason = ofd_pkg::RSN_HEADER;
      end else if ((kind == ofd_pkg::KIND_BEACON) ? (rcv != 16'd0) : (rcv == 16'd0)) begin
        reason = ofd_pkg::RSN_HEADER;
      end
    end
    if (reason == ofd_pkg::RSN_OK) begin
      if (stream == 32'd0 || opid == 32'd0) begin
        reason = ofd_pkg::RSN_PAYLOAD;
      end else if (kind == ofd_pkg::KIND_DATA) begin
        if (store_r[17] != 8'd0 || {store_r[19], store_r[18]} != 16'd0) begin
          reason = ofd_pkg::RSN_PAYLOAD;
        end else if (optype != add_op_r && optype != rem_op_r) begin
          reason = ofd_pkg::RSN_PAYLOAD;
        end else if (val > ofd_pkg::MAX_VALUE) begin
          reason = ofd_pkg::RSN_PAYLOAD;
        end
      end
    end

    res_nxt = '0;
    res_nxt.fail_reason = reason;
    if (reason == ofd_pkg::RSN_OK) begin
      res_nxt.frame_ok     = 1'b1;
      res_nxt.msg_kind     = kind;
      res_nxt.src_addr     = snd;
      res_nxt.dst_addr     = rcv;
      res_nxt.seq_num      = seq;
      res_nxt.flow_tag     = stream;
      res_nxt.op_id_word   = opid;
      res_nxt.op_type_code = optype;
      res_nxt.value_word   = val[26:0];
      res_nxt.nack_code    = ncode;
      res_nxt.nack_detail  = ndet;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && is_eof) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r   <= 8'd1;
      beacon_r    <= 8'd1;
      request_r   <= 8'd2;
      data_r      <= 8'd3;
      ack_r       <= 8'd4;
      nack_r      <= 8'd5;
      add_op_r    <= 8'd1;
      rem_op_r    <= 8'd2;
      count_r     <= '0;
      crc_r       <= ofd_pkg::CRC_INIT;
      dly0_r      <= '0;
      dly1_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ofd_pkg::CFG_VERSION: version_r <= cfg_data;
          ofd_pkg::CFG_BEACON:  beacon_r  <= cfg_data;
          ofd_pkg::CFG_REQUEST: request_r <= cfg_data;
          ofd_pkg::CFG_DATA:    data_r    <= cfg_data;
          ofd_pkg::CFG_ACK:     ack_r     <= cfg_data;
          ofd_pkg::CFG_NACK:    nack_r    <= cfg_data;
          ofd_pkg::CFG_ADD_OP:  add_op_r  <= cfg_data;
          ofd_pkg::CFG_REM_OP:  rem_op_r  <= cfg_data;
          default: ;
        endcase
      end
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      dly0_r      <= dly0_nxt;
      dly1_r      <= dly1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Byte store and result register hold payload only.
  always_ff @(posedge clk) begin
    if (in_acc && count_r < 6'(ofd_pkg::STORE_BYTES)) begin
      store_r[count_r[4:0]] <= in_req.rx_byte;
    end
    if (in_acc && is_eof) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A final byte must leave the frame state ready for the next frame.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_eof |=> count_r == 6'd0 && crc_r == ofd_pkg::CRC_INIT &&
                         dly0_r == 8'd0 && dly1_r == 8'd0)
    else $error("frame state not restored after final byte");

  // A verdict only appears after a final byte was taken.
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && is_eof))
    else $error("verdict without a final byte");

  a_ok_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.frame_ok == (out_res_r.fail_reason == ofd_pkg::RSN_OK)))
    else $error("frame_ok disagrees with fail_reason");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.frame_ok |-> out_res_r.src_addr == 16'd0 &&
      out_res_r.flow_tag == 32'd0 && out_res_r.msg_kind == ofd_pkg::KIND_BEACON)
    else $error("failed frame carries field data");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.frame_ok |->
      {5'd0, out_res_r.value_word} <= ofd_pkg::MAX_VALUE)
    else $error("value out of range on an accepted frame");

endmodule

// ----- tb/sv/tb_op_frame_decoder_crc16.sv -----
// Self-checking testbench for the CRC-16 framed message decoder.
`timescale 1ns / 1ps

module tb_op_frame_decoder_crc16;
  import ofd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int PHASES = 6;
  localparam int PHASE_BYTES = 160;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [3:0] {
    FLT_NONE, FLT_TYPE, FLT_LEN, FLT_CRC, FLT_VERSION, FLT_SENDER, FLT_RECEIVER,
    FLT_STREAM, FLT_OPID, FLT_RESV, FLT_OPTYPE, FLT_VALUE, FLT_SHORT1, FLT_SHORT2,
    FLT_LONG, FLT_NOISE
  } fault_e;

  typedef enum logic [1:0] {SET_RESET, SET_RANDOM, SET_EXTREME, SET_DUPLICATE} cfg_set_e;

  typedef struct packed {
    logic [2:0] kind;
    fault_e     flt;
    logic       typed;
    logic [2:0] reason;
  } row_t;

  // Directed frames; rows marked typed carry their verdict, the rest use the predictor.
  localparam row_t DIR_ROWS [22] = '{
    '{KIND_BEACON,  FLT_SHORT1,   1'b1, RSN_TYPE},
    '{KIND_REQUEST, FLT_SHORT2,   1'b1, RSN_LENGTH},
    '{KIND_BEACON,  FLT_NONE,     1'b0, RSN_OK},
    '{KIND_REQUEST, FLT_NONE,     1'b0, RSN_OK},
    '{KIND_DATA,    FLT_NONE,     1'b0, RSN_OK},
    '{KIND_ACK,     FLT_NONE,     1'b0, RSN_OK},
    '{KIND_NACK,    FLT_NONE,     1'b0, RSN_OK},
    '{KIND_DATA,    FLT_TYPE,     1'b1, RSN_TYPE},
    '{KIND_ACK,     FLT_LEN,      1'b1, RSN_LENGTH},
    '{KIND_NACK,    FLT_LONG,     1'b1, RSN_LENGTH},
    '{KIND_BEACON,  FLT_CRC,      1'b1, RSN_CRC},
    '{KIND_DATA,    FLT_CRC,      1'b1, RSN_CRC},
    '{KIND_REQUEST, FLT_VERSION,  1'b1, RSN_HEADER},
    '{KIND_NACK,    FLT_SENDER,   1'b1, RSN_HEADER},
    '{KIND_BEACON,  FLT_RECEIVER, 1'b1, RSN_HEADER},
    '{KIND_ACK,     FLT_RECEIVER, 1'b1, RSN_HEADER},
    '{KIND_REQUEST, FLT_STREAM,   1'b1, RSN_PAYLOAD},
    '{KIND_NACK,    FLT_OPID,     1'b1, RSN_PAYLOAD},
    '{KIND_DATA,    FLT_RESV,     1'b1, RSN_PAYLOAD},
    '{KIND_DATA,    FLT_OPTYPE,   1'b1, RSN_PAYLOAD},
    '{KIND_DATA,    FLT_VALUE,    1'b1, RSN_PAYLOAD},
    '{KIND_DATA,    FLT_NONE,     1'b0, RSN_OK}
  };

  localparam cfg_set_e PHASE_SET [PHASES] = '{
    SET_RANDOM, SET_EXTREME, SET_DUPLICATE, SET_RANDOM, SET_RESET, SET_RANDOM
  };
  localparam int PHASE_SEND_IDLE [PHASES] = '{0, 76, 0, 18, 0, 76};
  localparam int PHASE_STALL [PHASES]     = '{0, 0, 76, 18, 0, 0};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_req_t    in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_res_t   out_res;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // Decoder state as the testbench tracks it.
  logic [7:0]  cfg_reg [8];
  logic [5:0]  frame_cnt;
  logic [15:0] frame_crc;
  logic [7:0]  crc_hold [2];
  logic [7:0]  frame_store [STORE_BYTES];

  out_res_t    verdict_q [$];
  logic [7:0]  frame_q [$];
  int          err_count = 0;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  op_frame_decoder_crc16 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_op_frame_decoder_crc16: errors");
      $finish;
    end
  end

  // Receiver: a long hold-off when asked, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [5:0] frame_len(logic [2:0] kind);
    case (kind)
      KIND_DATA: return LEN_DATA;
      KIND_NACK: return LEN_NACK;
      default:   return LEN_SHORT;
    endcase
  endfunction

  function automatic logic [15:0] le16(int i);
    return {frame_store[i + 1], frame_store[i]};
  endfunction

  function automatic logic [31:0] le32(int i);
    return {le16(i + 2), le16(i)};
  endfunction

  // Steps the tracked state by one byte; a final byte yields a verdict.
  function automatic void decode_byte(input logic [7:0] b, input logic eof,
                                      output logic has, output out_res_t res);
    int          idx;
    int          len;
    logic [2:0]  reason;
    logic [2:0]  kind;
    logic [7:0]  t;
    logic [15:0] rx_crc, snd, rcv, seq, ncode, ndet;
    logic [31:0] stream, opid, val;
    logic [7:0]  optype;
    res = '0;
    has = 1'b0;
    idx = int'(frame_cnt);
    if (idx >= 2) frame_crc = crc_byte(frame_crc, crc_hold[1]);
    if (idx < STORE_BYTES) frame_store[idx] = b;
    if (!eof) begin
      crc_hold[1] = crc_hold[0];
      crc_hold[0] = b;
      if (frame_cnt != COUNT_MAX) frame_cnt++;
      return;
    end
    len = (idx < int'(COUNT_MAX)) ? idx + 1 : int'(COUNT_MAX);
    rx_crc = {b, crc_hold[0]};
    reason = RSN_OK;
    kind = KIND_BEACON;
    {snd, rcv, seq, ncode, ndet} = '0;
    {stream, opid, val} = '0;
    optype = '0;
    if (len < 2) begin
      reason = RSN_TYPE;
    end else begin
      t = frame_store[1];
      if (t == cfg_reg[CFG_BEACON]) kind = KIND_BEACON;
      else if (t == cfg_reg[CFG_REQUEST]) kind = KIND_REQUEST;
      else if (t == cfg_reg[CFG_DATA]) kind = KIND_DATA;
      else if (t == cfg_reg[CFG_ACK]) kind = KIND_ACK;
      else if (t == cfg_reg[CFG_NACK]) kind = KIND_NACK;
      else reason = RSN_TYPE;
    end
    if (reason == RSN_OK && len != int'(frame_len(kind))) reason = RSN_LENGTH;
    if (reason == RSN_OK && rx_crc != frame_crc) reason = RSN_CRC;
    if (reason == RSN_OK) begin
      snd = le16(2);
      rcv = le16(4);
      seq = le16(6);
      if (frame_store[0] != cfg_reg[CFG_VERSION] || snd == 0) reason = RSN_HEADER;
      else if ((kind == KIND_BEACON) ? (rcv != 0) : (rcv == 0)) reason = RSN_HEADER;
    end
    if (reason == RSN_OK) begin
      stream = le32(8);
      if (kind == KIND_NACK) begin
        ncode = le16(12);
        ndet = le16(14);
        opid = le32(16);
      end else begin
        opid = le32(12);
      end
      if (stream == 0 || opid == 0) reason = RSN_PAYLOAD;
      if (reason == RSN_OK && kind == KIND_DATA) begin
        optype = frame_store[16];
        val = le32(20);
        if (frame_store[17] != 0 || le16(18) != 0) reason = RSN_PAYLOAD;
        else if (optype != cfg_reg[CFG_ADD_OP] && optype != cfg_reg[CFG_REM_OP])
          reason = RSN_PAYLOAD;
        else if (val > MAX_VALUE) reason = RSN_PAYLOAD;
      end
    end
    frame_cnt = '0;
    frame_crc = CRC_INIT;
    crc_hold[0] = '0;
    crc_hold[1] = '0;
    has = 1'b1;
    res.fail_reason = reason;
    if (reason == RSN_OK) begin
      res.frame_ok = 1'b1;
      res.msg_kind = kind;
      res.src_addr = snd;
      res.dst_addr = rcv;
      res.seq_num = seq;
      res.flow_tag = stream;
      res.op_id_word = opid;
      res.op_type_code = optype;
      res.value_word = val[26:0];
      res.nack_code = ncode;
      res.nack_detail = ndet;
    end
  endfunction

  task automatic put_le(input int pos, input int nbytes, input logic [31:0] w);
    for (int k = 0; k < nbytes; k++) frame_q[pos + k] = 8'(w >> (8 * k));
  endtask

  // Builds a frame of the given kind in frame_q, then breaks it as the fault asks.
  task automatic build_frame(input logic [2:0] kind, input fault_e flt);
    logic [31:0] w;
    logic [15:0] crc;
    logic [7:0]  b;
    int          new_len;
    frame_q.delete();
    case (flt)
      FLT_SHORT1: begin
        frame_q.push_back(8'($urandom));
        return;
      end
      FLT_SHORT2: begin
        frame_q.push_back(cfg_reg[CFG_VERSION]);
        frame_q.push_back(cfg_reg[CFG_BEACON + kind]);
        return;
      end
      FLT_NOISE: begin
        repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
        return;
      end
      default: ;
    endcase
    repeat (frame_len(kind) - 2) frame_q.push_back(8'($urandom));
    frame_q[0] = cfg_reg[CFG_VERSION];
    frame_q[1] = cfg_reg[CFG_BEACON + kind];
    put_le(2, 2, $urandom_range(1, 65535));
    put_le(4, 2, (kind == KIND_BEACON) ? 0 : $urandom_range(1, 65535));
    w = $urandom;
    if (w == 0) w = 1;
    put_le(8, 4, w);
    w = $urandom;
    if (w == 0) w = 1;
    put_le((kind == KIND_NACK) ? 16 : 12, 4, w);
    if (kind == KIND_DATA) begin
      frame_q[16] = $urandom_range(1) ? cfg_reg[CFG_ADD_OP] : cfg_reg[CFG_REM_OP];
      put_le(17, 3, 0);
      case ($urandom_range(3))
        0: w = 0;
        1: w = MAX_VALUE;
        default: w = $urandom_range(0, MAX_VALUE);
      endcase
      put_le(20, 4, w);
    end
    case (flt)
      FLT_TYPE: begin
        do b = 8'($urandom);
        while (b == cfg_reg[CFG_BEACON] || b == cfg_reg[CFG_REQUEST] ||
               b == cfg_reg[CFG_DATA] || b == cfg_reg[CFG_ACK] || b == cfg_reg[CFG_NACK]);
        frame_q[1] = b;
      end
      FLT_VERSION: frame_q[0] = cfg_reg[CFG_VERSION] ^ (8'h01 << $urandom_range(7));
      FLT_SENDER:  put_le(2, 2, 0);
      FLT_RECEIVER: put_le(4, 2, (kind == KIND_BEACON) ? $urandom_range(1, 65535) : 0);
      FLT_STREAM:  put_le(8, 4, 0);
      FLT_OPID:    put_le((kind == KIND_NACK) ? 16 : 12, 4, 0);
      FLT_RESV: begin
        if (kind == KIND_DATA) begin
          if ($urandom_range(1)) frame_q[17] = 8'($urandom_range(1, 255));
          else put_le(18, 2, $urandom_range(1, 65535));
        end
      end
      FLT_OPTYPE: begin
        if (kind == KIND_DATA) begin
          do b = 8'($urandom);
          while (b == cfg_reg[CFG_ADD_OP] || b == cfg_reg[CFG_REM_OP]);
          frame_q[16] = b;
        end
      end
      FLT_VALUE: begin
        if (kind == KIND_DATA)
          put_le(20, 4, $urandom_range(1) ? MAX_VALUE + 1 :
                        $urandom_range(MAX_VALUE + 1, 32'hFFFF_FFFF));
      end
      FLT_LEN: begin
        do new_len = $urandom_range(3, 40);
        while (new_len == int'(frame_len(kind)));
        while (frame_q.size() > new_len - 2) void'(frame_q.pop_back());
        while (frame_q.size() < new_len - 2) frame_q.push_back(8'($urandom));
      end
      FLT_LONG: begin
        new_len = $urandom_range(64, 80);
        while (frame_q.size() < new_len - 2) frame_q.push_back(8'($urandom));
      end
      default: ;
    endcase
    crc = CRC_INIT;
    foreach (frame_q[k]) crc = crc_byte(crc, frame_q[k]);
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
    if (flt == FLT_CRC)
      frame_q[frame_q.size() - 1 - $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
  endtask

  // Offers one byte request and waits until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic eof,
                           input logic typed, input out_res_t typed_res);
    logic     has;
    out_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= in_req_t'{rx_byte: b, end_of_frame: eof};
    do @(posedge clk);
    while (in_stall);
    decode_byte(b, eof, has, res);
    if (has) verdict_q.push_back(typed ? typed_res : res);
  endtask

  task automatic send_frame(input logic typed, input out_res_t typed_res);
    foreach (frame_q[k])
      send_byte(frame_q[k], k == frame_q.size() - 1, typed, typed_res);
  endtask

  // Stops offering and waits until every expected verdict has been taken.
  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input cfg_set_e set);
    logic [7:0] v [8];
    logic       dup;
    case (set)
      SET_RESET: begin
        v[CFG_VERSION] = 8'd1; v[CFG_BEACON] = 8'd1; v[CFG_REQUEST] = 8'd2;
        v[CFG_DATA] = 8'd3; v[CFG_ACK] = 8'd4; v[CFG_NACK] = 8'd5;
        v[CFG_ADD_OP] = 8'd1; v[CFG_REM_OP] = 8'd2;
      end
      SET_EXTREME: begin
        v[CFG_VERSION] = 8'h00; v[CFG_BEACON] = 8'hFF; v[CFG_REQUEST] = 8'h00;
        v[CFG_DATA] = 8'h80; v[CFG_ACK] = 8'h7F; v[CFG_NACK] = 8'h01;
        v[CFG_ADD_OP] = 8'h00; v[CFG_REM_OP] = 8'hFF;
      end
      SET_DUPLICATE: begin
        // Shared type codes: the earlier kind in the match order must win.
        v[CFG_VERSION] = 8'hFF; v[CFG_BEACON] = 8'h33; v[CFG_REQUEST] = 8'h33;
        v[CFG_DATA] = 8'hFF; v[CFG_ACK] = 8'hFF; v[CFG_NACK] = 8'h00;
        v[CFG_ADD_OP] = 8'hFF; v[CFG_REM_OP] = 8'hFF;
      end
      default: begin
        foreach (v[k]) v[k] = 8'($urandom);
        for (int k = CFG_BEACON; k <= CFG_NACK; k++) begin
          do begin
            v[k] = 8'($urandom);
            dup = 1'b0;
            for (int j = CFG_BEACON; j < k; j++) if (v[j] == v[k]) dup = 1'b1;
          end while (dup);
        end
      end
    endcase
    foreach (v[k]) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(k);
      cfg_data <= v[k];
      @(posedge clk);
      cfg_reg[k] = v[k];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with no expectation waiting");
        err_count++;
      end else begin
        want = verdict_q.pop_front();
        check_field("frame_ok", 32'(want.frame_ok), 32'(out_res.frame_ok));
        check_field("fail_reason", 32'(want.fail_reason), 32'(out_res.fail_reason));
        check_field("msg_kind", 32'(want.msg_kind), 32'(out_res.msg_kind));
        check_field("src_addr", 32'(want.src_addr), 32'(out_res.src_addr));
        check_field("dst_addr", 32'(want.dst_addr), 32'(out_res.dst_addr));
        check_field("seq_num", 32'(want.seq_num), 32'(out_res.seq_num));
        check_field("flow_tag", want.flow_tag, out_res.flow_tag);
        check_field("op_id_word", want.op_id_word, out_res.op_id_word);
        check_field("op_type_code", 32'(want.op_type_code), 32'(out_res.op_type_code));
        check_field("value_word", 32'(want.value_word), 32'(out_res.value_word));
        check_field("nack_code", 32'(want.nack_code), 32'(out_res.nack_code));
        check_field("nack_detail", 32'(want.nack_detail), 32'(out_res.nack_detail));
      end
    end
  end

  initial begin
    int         sent;
    int         frames;
    logic [2:0] kind;
    fault_e     flt;
    out_res_t   typed_res;
    cfg_reg[CFG_VERSION] = 8'd1;
    cfg_reg[CFG_BEACON] = 8'd1;
    cfg_reg[CFG_REQUEST] = 8'd2;
    cfg_reg[CFG_DATA] = 8'd3;
    cfg_reg[CFG_ACK] = 8'd4;
    cfg_reg[CFG_NACK] = 8'd5;
    cfg_reg[CFG_ADD_OP] = 8'd1;
    cfg_reg[CFG_REM_OP] = 8'd2;
    frame_cnt = '0;
    frame_crc = CRC_INIT;
    crc_hold[0] = '0;
    crc_hold[1] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[r]) begin
      build_frame(DIR_ROWS[r].kind, DIR_ROWS[r].flt);
      typed_res = '0;
      typed_res.fail_reason = DIR_ROWS[r].reason;
      send_frame(DIR_ROWS[r].typed, typed_res);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_verdicts();
      apply_setting(PHASE_SET[ph]);
      send_idle_pct = PHASE_SEND_IDLE[ph];
      stall_pct = PHASE_STALL[ph];
      // A long receiver hold-off while bytes keep coming fills the block up.
      if (ph == 2) hold_left = HOLD_CYCLES;
      sent = 0;
      frames = 0;
      while (sent < PHASE_BYTES) begin
        kind = 3'($urandom_range(KIND_NACK, KIND_BEACON));
        flt = ($urandom_range(99) < 65) ? FLT_NONE : fault_e'($urandom_range(1, 15));
        build_frame(kind, flt);
        send_frame(1'b0, '0);
        sent += frame_q.size();
        frames++;
        if (ph == 3 && frames % 5 == 0) drain_verdicts();
      end
    end
    drain_verdicts();

    if (err_count == 0) begin
      $display("tb_op_frame_decoder_crc16: clean");
    end else begin
      $display("tb_op_frame_decoder_crc16: errors");
    end
    $finish;
  end

endmodule
